/* rtl/psd_pkg.sv */
package psd_pkg;

  // fraction bits of the projection parameter
  localparam int U_FRAC = 24;
  // fraction bits of the foot offsets before squaring
  localparam int D_FRAC = 12;

endpackage

/* rtl/point_segment_distance_top.sv */
// point to segment distance, fully pipelined
//
// input channel (in_valid / in_stall): one word holds a segment with integer
// endpoints (start, end) and a query point with FRAC_BITS fraction bits
// output channel (out_valid / out_stall): one word per input word holding the
// distance from the query point to its nearest point on the segment, unsigned,
// FRAC_BITS fraction bits, truncated
//
// the pipe runs the set-up products, 2*24+1 restoring division steps
// (projection and 2^48/len^2 side by side), 25 square root steps for the
// 1/len bound, the clamp, foot and squares stages, (2*(COORD_BITS+12+1)+2)/2
// square root steps for the distance and the output register
// throughput is one word per cycle unless a held output word stalls the pipe;
// each divider or root stage is one step; the 2^48/len^2 width sets divider depth
//
// reset clears every valid bit; data registers are not reset
// a stalled output word holds; the whole pipe freezes with it and in_stall
// rises in the same cycle, so nothing is dropped or repeated
module point_segment_distance_top
  import psd_pkg::*;
#(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 4
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [COORD_BITS-1:0]         in_start_x,
  input  logic signed [COORD_BITS-1:0]         in_start_y,
  input  logic signed [COORD_BITS-1:0]         in_end_x,
  input  logic signed [COORD_BITS-1:0]         in_end_y,
  input  logic signed [COORD_BITS+FRAC_BITS-1:0] in_query_x,
  input  logic signed [COORD_BITS+FRAC_BITS-1:0] in_query_y,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [COORD_BITS+FRAC_BITS:0]        out_dist_out
);

  localparam int C     = COORD_BITS;
  localparam int F     = FRAC_BITS;
  localparam int QW    = C + F;              // query width
  localparam int DXW   = C + 1;              // endpoint difference
  localparam int L2W   = 2 * C + 2;          // squared length
  localparam int RW    = QW + 1;             // query minus start
  localparam int NW    = RW + DXW + 1;       // projection numerator
  localparam int NDW   = NW - 1 + U_FRAC - F; // scaled numerator magnitude
  localparam int UQB   = U_FRAC + 2;         // quotient bits kept for u
  localparam int TOPW  = NDW - UQB;
  localparam int LQW   = 2 * U_FRAC + 1;     // 2^48 / len^2 quotient
  localparam int DIVN  = LQW;
  localparam int SQ1N  = (LQW + 1) / 2;      // bound root bits
  localparam int UW    = U_FRAC + 1;         // clamped u, 0 .. 1.0
  localparam int PW    = UW + 1 + DXW;       // u * dx
  localparam int DDW   = C + U_FRAC + 4;     // query - foot, 24 fraction bits
  localparam int FW    = DDW - (U_FRAC - D_FRAC);
  localparam int MW    = C + D_FRAC + 1;     // offset magnitude
  localparam int SW    = 2 * MW + 1;         // sum of squares
  localparam int SQ2N  = (SW + 1) / 2;       // distance root bits
  localparam int OUTW  = C + F + 1;

  typedef struct packed {
    logic signed [C-1:0]   sx;
    logic signed [C-1:0]   sy;
    logic signed [QW-1:0]  qx;
    logic signed [QW-1:0]  qy;
    logic signed [DXW-1:0] dx;
    logic signed [DXW-1:0] dy;
  } ctx_t;

  typedef struct packed {
    ctx_t                 ctx;
    logic signed [RW-1:0] rx;
    logic signed [RW-1:0] ry;
  } sa_t;

  typedef struct packed {
    ctx_t                       ctx;
    logic signed [2*DXW-1:0]    pxx;
    logic signed [2*DXW-1:0]    pyy;
    logic signed [RW+DXW-1:0]   pnx;
    logic signed [RW+DXW-1:0]   pny;
  } sb_t;

  typedef struct packed {
    ctx_t                 ctx;
    logic [L2W-1:0]       l2;
    logic signed [NW-1:0] num;
  } sc_t;

  typedef struct packed {
    ctx_t           ctx;
    logic [L2W-1:0] l2;
    logic           zero;
    logic           neg;
    logic           ovf;
    logic [L2W:0]   urem;
    logic [UQB-1:0] ubits;
    logic [UQB-1:0] uq;
    logic [L2W:0]   lrem;
    logic [LQW-1:0] lq;
  } div_t;

  typedef struct packed {
    ctx_t              ctx;
    logic              zero;
    logic [UQB-1:0]    uq;
    logic [2*SQ1N-1:0] rad;
    logic [SQ1N-1:0]   root;
    logic [SQ1N+1:0]   rem;
  } sq1_t;

  typedef struct packed {
    ctx_t          ctx;
    logic [UW-1:0] u;
  } se_t;

  typedef struct packed {
    ctx_t                 ctx;
    logic signed [PW-1:0] pux;
    logic signed [PW-1:0] puy;
  } sf_t;

  typedef struct packed {
    logic [MW-1:0] mx;
    logic [MW-1:0] my;
  } sg_t;

  typedef struct packed {
    logic [2*MW-1:0] sxx;
    logic [2*MW-1:0] syy;
  } sh_t;

  typedef struct packed {
    logic [2*SQ2N-1:0] rad;
    logic [SQ2N-1:0]   root;
    logic [SQ2N+1:0]   rem;
  } sq2_t;

  logic en;

  // whole pipe advances unless the output word is held
  assign in_stall = out_valid & out_stall;
  assign en       = ~in_stall;

  // ---------------------------------------------------------------- set-up
  sa_t a_r, a_nxt;
  sb_t b_r, b_nxt;
  sc_t c_r, c_nxt;
  logic a_v_r, b_v_r, c_v_r;

  always_comb begin
    a_nxt.ctx.sx = in_start_x;
    a_nxt.ctx.sy = in_start_y;
    a_nxt.ctx.qx = in_query_x;
    a_nxt.ctx.qy = in_query_y;
    a_nxt.ctx.dx = DXW'(in_end_x) - DXW'(in_start_x);
    a_nxt.ctx.dy = DXW'(in_end_y) - DXW'(in_start_y);
    a_nxt.rx     = RW'(in_query_x) - (RW'(in_start_x) <<< F);
    a_nxt.ry     = RW'(in_query_y) - (RW'(in_start_y) <<< F);
  end

  always_comb begin
    b_nxt.ctx = a_r.ctx;
    b_nxt.pxx = a_r.ctx.dx * a_r.ctx.dx;
    b_nxt.pyy = a_r.ctx.dy * a_r.ctx.dy;
    b_nxt.pnx = a_r.rx * a_r.ctx.dx;
    b_nxt.pny = a_r.ry * a_r.ctx.dy;
  end

  always_comb begin
    c_nxt.ctx = b_r.ctx;
    c_nxt.l2  = L2W'(b_r.pxx) + L2W'(b_r.pyy);
    c_nxt.num = NW'(b_r.pnx) + NW'(b_r.pny);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_valid;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
    end
    if (en) begin
      a_r <= a_nxt;
      b_r <= b_nxt;
      c_r <= c_nxt;
    end
  end

  // ---------------------------------------------------------------- dividers
  // projection quotient num*2^20/len^2 and 2^48/len^2 run side by side,
  // one restoring step each per stage until the UQB projection bits are done
  div_t              div_in;
  div_t              div_r [DIVN];
  logic [DIVN-1:0]   div_v_r;
  logic [NDW-1:0]    nd;
  logic [TOPW-1:0]   ntop;

  always_comb begin
    nd            = {c_r.num[NW-2:0], {(U_FRAC - F){1'b0}}};
    ntop          = nd[NDW-1:UQB];
    div_in.ctx    = c_r.ctx;
    div_in.l2     = c_r.l2;
    div_in.zero   = (c_r.l2 == '0);
    div_in.neg    = c_r.num[NW-1];
    // quotient would not fit in the kept bits
    div_in.ovf    = (L2W'(ntop) >= c_r.l2);
    div_in.urem   = (L2W+1)'(ntop);
    div_in.ubits  = nd[UQB-1:0];
    div_in.uq     = '0;
    div_in.lrem   = '0;
    div_in.lq     = '0;
  end

  for (genvar g = 0; g < DIVN; g++) begin : g_div
    div_t         prev;
    div_t         div_nxt;
    logic [L2W:0] lrem2;
    logic [L2W:0] urem2;

    if (g == 0) begin : g_first
      assign prev = div_in;
    end else begin : g_next
      assign prev = div_r[g-1];
    end

    always_comb begin
      div_nxt = prev;
      // dividend 2^48: only its top bit is set
      lrem2   = {prev.lrem[L2W-1:0], (g == 0) ? 1'b1 : 1'b0};
      if (lrem2 >= {1'b0, prev.l2}) begin
        div_nxt.lrem = lrem2 - {1'b0, prev.l2};
        div_nxt.lq   = {prev.lq[LQW-2:0], 1'b1};
      end else begin
        div_nxt.lrem = lrem2;
        div_nxt.lq   = {prev.lq[LQW-2:0], 1'b0};
      end
      urem2 = {prev.urem[L2W-1:0], prev.ubits[UQB-1]};
      if (g < UQB) begin
        div_nxt.ubits = prev.ubits << 1;
        if (urem2 >= {1'b0, prev.l2}) begin
          div_nxt.urem = urem2 - {1'b0, prev.l2};
          div_nxt.uq   = {prev.uq[UQB-2:0], 1'b1};
        end else begin
          div_nxt.urem = urem2;
          div_nxt.uq   = {prev.uq[UQB-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        div_v_r[g] <= 1'b0;
      end else if (en) begin
        div_v_r[g] <= (g == 0) ? c_v_r : div_v_r[(g == 0) ? 0 : g-1];
      end
      if (en) begin
        div_r[g] <= div_nxt;
      end
    end
  end

  // ---------------------------------------------------------------- bound root
  // lb = isqrt(2^48 / len^2), one root bit per stage
  sq1_t            sq1_in;
  sq1_t            sq1_r [SQ1N];
  logic [SQ1N-1:0] sq1_v_r;

  always_comb begin
    sq1_in.ctx  = div_r[DIVN-1].ctx;
    sq1_in.zero = div_r[DIVN-1].zero;
    // negative projection sits below any bound, an oversized one above
    if (div_r[DIVN-1].neg) begin
      sq1_in.uq = '0;
    end else if (div_r[DIVN-1].ovf) begin
      sq1_in.uq = '1;
    end else begin
      sq1_in.uq = div_r[DIVN-1].uq;
    end
    sq1_in.rad  = (2*SQ1N)'(div_r[DIVN-1].lq);
    sq1_in.root = '0;
    sq1_in.rem  = '0;
  end

  for (genvar g = 0; g < SQ1N; g++) begin : g_sq1
    sq1_t            prev;
    sq1_t            sq1_nxt;
    logic [SQ1N+3:0] rem2;
    logic [SQ1N+3:0] trial;

    if (g == 0) begin : g_first
      assign prev = sq1_in;
    end else begin : g_next
      assign prev = sq1_r[g-1];
    end

    always_comb begin
      sq1_nxt     = prev;
      rem2        = {prev.rem, prev.rad[2*SQ1N-1 -: 2]};
      trial       = {2'b00, prev.root, 2'b01};
      sq1_nxt.rad = prev.rad << 2;
      if (rem2 >= trial) begin
        sq1_nxt.rem  = (SQ1N+2)'(rem2 - trial);
        sq1_nxt.root = {prev.root[SQ1N-2:0], 1'b1};
      end else begin
        sq1_nxt.rem  = rem2[SQ1N+1:0];
        sq1_nxt.root = {prev.root[SQ1N-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq1_v_r[g] <= 1'b0;
      end else if (en) begin
        sq1_v_r[g] <= (g == 0) ? div_v_r[DIVN-1] : sq1_v_r[(g == 0) ? 0 : g-1];
      end
      if (en) begin
        sq1_r[g] <= sq1_nxt;
      end
    end
  end

  // ---------------------------------------------------------------- clamp, foot
  se_t            e_r, e_nxt;
  sf_t            f_r, f_nxt;
  sg_t            g_r, g_nxt;
  sh_t            h_r, h_nxt;
  logic [SW-1:0]  i_r, i_nxt;
  logic           e_v_r, f_v_r, g_v_r, h_v_r, i_v_r;
  logic [UW-1:0]  lb, ub;
  logic [UQB-1:0] ut;
  logic signed [DDW-1:0] ddx, ddy;
  logic signed [FW-1:0]  fx, fy, ax, ay;

  always_comb begin
    lb = UW'(sq1_r[SQ1N-1].root);
    ub = (UW'(1) << U_FRAC) - lb;
    // lower bound first, upper bound wins when they cross
    ut = (sq1_r[SQ1N-1].uq < UQB'(lb)) ? UQB'(lb) : sq1_r[SQ1N-1].uq;
    e_nxt.ctx = sq1_r[SQ1N-1].ctx;
    if (sq1_r[SQ1N-1].zero) begin
      e_nxt.u = '0;
    end else if (ut > UQB'(ub)) begin
      e_nxt.u = ub;
    end else begin
      e_nxt.u = UW'(ut);
    end
  end

  always_comb begin
    f_nxt.ctx = e_r.ctx;
    f_nxt.pux = $signed({1'b0, e_r.u}) * e_r.ctx.dx;
    f_nxt.puy = $signed({1'b0, e_r.u}) * e_r.ctx.dy;
  end

  always_comb begin
    ddx = (DDW'(f_r.ctx.qx) <<< (U_FRAC - F)) - (DDW'(f_r.ctx.sx) <<< U_FRAC)
        - DDW'(f_r.pux);
    ddy = (DDW'(f_r.ctx.qy) <<< (U_FRAC - F)) - (DDW'(f_r.ctx.sy) <<< U_FRAC)
        - DDW'(f_r.puy);
    // floor to 12 fraction bits
    fx = FW'(ddx >>> (U_FRAC - D_FRAC));
    fy = FW'(ddy >>> (U_FRAC - D_FRAC));
    ax = fx[FW-1] ? -fx : fx;
    ay = fy[FW-1] ? -fy : fy;
    g_nxt.mx = ax[MW-1:0];
    g_nxt.my = ay[MW-1:0];
  end

  always_comb begin
    h_nxt.sxx = g_r.mx * g_r.mx;
    h_nxt.syy = g_r.my * g_r.my;
    i_nxt     = SW'(h_r.sxx) + SW'(h_r.syy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
      f_v_r <= 1'b0;
      g_v_r <= 1'b0;
      h_v_r <= 1'b0;
      i_v_r <= 1'b0;
    end else if (en) begin
      e_v_r <= sq1_v_r[SQ1N-1];
      f_v_r <= e_v_r;
      g_v_r <= f_v_r;
      h_v_r <= g_v_r;
      i_v_r <= h_v_r;
    end
    if (en) begin
      e_r <= e_nxt;
      f_r <= f_nxt;
      g_r <= g_nxt;
      h_r <= h_nxt;
      i_r <= i_nxt;
    end
  end

  // ---------------------------------------------------------------- distance root
  sq2_t            sq2_in;
  sq2_t            sq2_r [SQ2N];
  logic [SQ2N-1:0] sq2_v_r;

  always_comb begin
    sq2_in.rad  = (2*SQ2N)'(i_r);
    sq2_in.root = '0;
    sq2_in.rem  = '0;
  end

  for (genvar g = 0; g < SQ2N; g++) begin : g_sq2
    sq2_t            prev;
    sq2_t            sq2_nxt;
    logic [SQ2N+3:0] rem2;
    logic [SQ2N+3:0] trial;

    if (g == 0) begin : g_first
      assign prev = sq2_in;
    end else begin : g_next
      assign prev = sq2_r[g-1];
    end

    always_comb begin
      sq2_nxt     = prev;
      rem2        = {prev.rem, prev.rad[2*SQ2N-1 -: 2]};
      trial       = {2'b00, prev.root, 2'b01};
      sq2_nxt.rad = prev.rad << 2;
      if (rem2 >= trial) begin
        sq2_nxt.rem  = (SQ2N+2)'(rem2 - trial);
        sq2_nxt.root = {prev.root[SQ2N-2:0], 1'b1};
      end else begin
        sq2_nxt.rem  = rem2[SQ2N+1:0];
        sq2_nxt.root = {prev.root[SQ2N-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq2_v_r[g] <= 1'b0;
      end else if (en) begin
        sq2_v_r[g] <= (g == 0) ? i_v_r : sq2_v_r[(g == 0) ? 0 : g-1];
      end
      if (en) begin
        sq2_r[g] <= sq2_nxt;
      end
    end
  end

  // ---------------------------------------------------------------- output word
  logic [SQ2N-1:0] d_sh;
  logic [OUTW-1:0] dist_nxt;
  logic [OUTW-1:0] dist_r;
  logic            out_valid_r;

  always_comb begin
    d_sh = sq2_r[SQ2N-1].root >> (D_FRAC - F);
    // saturate, unreachable for in-range words
    if (|(d_sh >> OUTW)) begin
      dist_nxt = '1;
    end else begin
      dist_nxt = d_sh[OUTW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= sq2_v_r[SQ2N-1];
    end
    if (en) begin
      dist_r <= dist_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_dist_out = dist_r;

endmodule
